>>> rtl/core/cpp_pkg.sv
// Shared types and constants for the correlation pattern prefetcher core.
// Depends on nothing; used by the core, its port checker and the testbench.
package cpp_pkg;

  localparam int ID_W        = 16;
  localparam int CONF_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CONF_W-1:0] CONF_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_LEARNING_RATE      = 16'd6554;
  localparam logic [CFG_DATA_W-1:0] RST_MIN_CONFIDENCE     = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] RST_INITIAL_CONFIDENCE = 16'd19661;
  localparam logic [CFG_DATA_W-1:0] RST_DECAY_FACTOR       = 16'd64881;
  localparam logic [CFG_DATA_W-1:0] RST_PRUNE_THRESHOLD    = 16'd6554;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEARNING_RATE      = 3'd0,
    REG_MIN_CONFIDENCE     = 3'd1,
    REG_INITIAL_CONFIDENCE = 3'd2,
    REG_DECAY_FACTOR       = 3'd3,
    REG_PRUNE_THRESHOLD    = 3'd4
  } cfg_reg_e;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic            func;
    logic [ID_W-1:0] resource_id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   followup_id;
    logic [CONF_W-1:0] confidence;
    logic              last;
  } hint_t;

endpackage

>>> rtl/core/correlation_pattern_prefetcher_core.sv
// Correlation pattern prefetcher core: pair table, sequencer and shared multiplier.
// Depends on cpp_pkg (types, register indexes, reset values).
//
// Usage: drive item and pulse start while busy is low; the item is accepted at that
// edge and busy rises. A record item (func 0) learns the pair (previous id, new id),
// then decays and prunes the whole table; it gives no results. A query item (func 1)
// lists the follow-ups of the last recorded id whose confidence is at least
// min_confidence, in table order, one per hint_valid pulse, with last set on the
// final one. hint is valid only in the cycle hint_valid is high; the receiver cannot
// stall and must take it then.
// A record makes one pass over the table, paced by the single table memory port pair
// and the one 16x17 multiplier, used once per entry for decay (twice for the hit
// entry, once for an appended pair). A query makes one pass reading the table.
// busy falls in the same cycle the final hint appears. A query with no id recorded,
// or an empty table, gives no result and leaves busy low.
// Configuration: cfg_we, cfg_index, cfg_data write a register. The user must write
// only while the core is idle; the core itself does not enforce this. Unknown indexes
// are ignored. Reset (rst, synchronous) empties the table and restores the register
// defaults; no clearing pass is needed.
module correlation_pattern_prefetcher_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  cpp_pkg::cmd_t                    item,
  output logic                             busy,
  output logic                             hint_valid,
  output cpp_pkg::hint_t                   hint,
  input  logic                             cfg_we,
  input  logic [cpp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cpp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cpp_pkg::*;

  localparam int SID_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW       = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [SID_BITS-1:0] trig;
    logic [SID_BITS-1:0] fol;
    logic [CONF_W-1:0]   conf;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_GAIN, S_DMUL, S_WR, S_TAIL, S_AMUL, S_AWR, S_FIN, S_QCHK, S_QEND
  } state_t;

  state_t state;

  logic [CONF_W-1:0] learning_rate, min_confidence, initial_confidence;
  logic [CONF_W-1:0] decay_factor, prune_threshold;

  logic [SID_BITS-1:0] last_used_id, cur_id;
  logic                have_last, hit_done;
  logic [CW-1:0]       entry_count, kept, idx, idx_next, idx_plus;

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata, pend, mem_wdata;
  logic   pend_valid, mem_we;
  logic [AW-1:0] mem_waddr;

  logic [CONF_W-1:0]   mul_a, conf_work, dec_conf;
  logic [CONF_W:0]     mul_b, sum_conf;
  logic [2*CONF_W-1:0] mul_p, prod;
  logic                match_pair, match_hint, dec_keep, accept;

  assign accept   = start && !busy;
  assign idx_plus = CW'(idx + 1'b1);

  always_comb begin
    case (state)
      S_IDLE:         idx_next = '0;
      S_WR, S_QCHK:   idx_next = idx_plus;
      default:        idx_next = idx;
    endcase
  end

  assign match_pair = have_last && !hit_done && (rdata.trig == last_used_id) &&
                      (rdata.fol == cur_id);
  assign match_hint = (rdata.trig == last_used_id) && (rdata.conf >= min_confidence);

  // Shared multiplier: gain on the hit entry, then decay on every entry
  always_comb begin
    case (state)
      S_CHK: begin
        if (match_pair) begin
          mul_a = learning_rate;
          mul_b = 17'h10000 - {1'b0, rdata.conf};
        end else begin
          mul_a = decay_factor;
          mul_b = {1'b0, rdata.conf};
        end
      end
      S_DMUL: begin
        mul_a = decay_factor;
        mul_b = {1'b0, conf_work};
      end
      S_AMUL: begin
        mul_a = decay_factor;
        mul_b = {1'b0, initial_confidence};
      end
      default: begin
        mul_a = decay_factor;
        mul_b = {1'b0, rdata.conf};
      end
    endcase
  end

  assign mul_p    = (2*CONF_W)'(mul_a) * (2*CONF_W)'(mul_b);
  assign dec_conf = prod[2*CONF_W-1:CONF_W];
  assign dec_keep = dec_conf >= prune_threshold;
  assign sum_conf = {1'b0, rdata.conf} + {1'b0, dec_conf};

  // Compact in place: the write slot never passes the read pointer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kept[AW-1:0];
    mem_wdata = '{trig: rdata.trig, fol: rdata.fol, conf: dec_conf};
    if (state == S_WR) begin
      mem_we = dec_keep;
    end else if (state == S_AWR) begin
      mem_we    = dec_keep;
      mem_wdata = '{trig: last_used_id, fol: cur_id, conf: dec_conf};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[idx_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate      <= RST_LEARNING_RATE;
      min_confidence     <= RST_MIN_CONFIDENCE;
      initial_confidence <= RST_INITIAL_CONFIDENCE;
      decay_factor       <= RST_DECAY_FACTOR;
      prune_threshold    <= RST_PRUNE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARNING_RATE:      learning_rate      <= cfg_data;
        REG_MIN_CONFIDENCE:     min_confidence     <= cfg_data;
        REG_INITIAL_CONFIDENCE: initial_confidence <= cfg_data;
        REG_DECAY_FACTOR:       decay_factor       <= cfg_data;
        REG_PRUNE_THRESHOLD:    prune_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      hint_valid   <= 1'b0;
      have_last    <= 1'b0;
      last_used_id <= '0;
      entry_count  <= '0;
      idx          <= '0;
      kept         <= '0;
      hit_done     <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      idx        <= idx_next;
      hint_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kept       <= '0;
            hit_done   <= 1'b0;
            pend_valid <= 1'b0;
            if (item.func == FUNC_RECORD) begin
              cur_id <= item.resource_id[SID_BITS-1:0];
              busy   <= 1'b1;
              state  <= (entry_count == '0) ? S_TAIL : S_CHK;
            end else if (have_last && entry_count != '0) begin
              busy  <= 1'b1;
              state <= S_QCHK;
            end
          end
        end
        S_CHK: begin
          prod <= mul_p;
          if (match_pair) begin
            hit_done <= 1'b1;
            state    <= S_GAIN;
          end else begin
            state <= S_WR;
          end
        end
        S_GAIN: begin
          conf_work <= sum_conf[CONF_W] ? CONF_MAX : sum_conf[CONF_W-1:0];
          state     <= S_DMUL;
        end
        S_DMUL: begin
          prod  <= mul_p;
          state <= S_WR;
        end
        S_WR: begin
          if (dec_keep) begin
            kept <= CW'(kept + 1'b1);
          end
          state <= (idx_plus == entry_count) ? S_TAIL : S_CHK;
        end
        S_TAIL: begin
          // Append an unseen pair only if the table had room before pruning
          if (have_last && !hit_done && entry_count < CW'(TABLE_ENTRIES)) begin
            state <= S_AMUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_AMUL: begin
          prod  <= mul_p;
          state <= S_AWR;
        end
        S_AWR: begin
          if (dec_keep) begin
            kept <= CW'(kept + 1'b1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          entry_count  <= kept;
          last_used_id <= cur_id;
          have_last    <= 1'b1;
          busy         <= 1'b0;
          state        <= S_IDLE;
        end
        S_QCHK: begin
          // Hold one hint back so the final one can carry last
          if (match_hint) begin
            if (pend_valid) begin
              hint_valid <= 1'b1;
              hint       <= '{followup_id: ID_W'(pend.fol), confidence: pend.conf,
                              last: 1'b0};
            end
            pend       <= rdata;
            pend_valid <= 1'b1;
          end
          if (idx_plus == entry_count) begin
            state <= S_QEND;
          end
        end
        S_QEND: begin
          if (pend_valid) begin
            hint_valid <= 1'b1;
            hint       <= '{followup_id: ID_W'(pend.fol), confidence: pend.conf,
                            last: 1'b1};
          end
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cpp_checker.sv
// Port-level checks for the correlation pattern prefetcher core, bound to its top level.
// Depends on cpp_pkg for the command and hint types.
module cpp_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input cpp_pkg::cmd_t  item,
  input logic           busy,
  input logic           hint_valid,
  input cpp_pkg::hint_t hint
);
  import cpp_pkg::*;

  // A hint only ever comes out of a busy cycle
  a_hint_from_busy: assert property (@(posedge clk) disable iff (rst)
    hint_valid |-> $past(busy))
    else $error("hint without a busy cycle before it");

  // Nothing comes out in the cycle right after an item is taken
  a_no_hint_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !hint_valid)
    else $error("hint right after accept");

  // Final hint closes the query
  a_last_ends_query: assert property (@(posedge clk) disable iff (rst)
    hint_valid && hint.last |-> !busy)
    else $error("busy after the final hint");

  a_last_then_quiet: assert property (@(posedge clk) disable iff (rst)
    hint_valid && hint.last |=> !hint_valid)
    else $error("hint after the final hint");

  // More hints pending keep the core busy
  a_more_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    hint_valid && !hint.last |-> busy)
    else $error("query dropped before its final hint");

endmodule

bind correlation_pattern_prefetcher_core cpp_checker u_cpp_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .item       (item),
  .busy       (busy),
  .hint_valid (hint_valid),
  .hint       (hint)
);

>>> sim/testbench.sv
// Self-checking testbench for correlation_pattern_prefetcher_core.
// Depends on cpp_pkg and the core; predicts every hint and checks them in order.
`timescale 1ns / 100ps

module testbench;
  import cpp_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int SETTLE      = 160;     // longer than the longest record
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  cmd_t                   item = '0;
  logic                   busy;
  logic                   hint_valid;
  hint_t                  hint;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  correlation_pattern_prefetcher_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .busy       (busy),
    .hint_valid (hint_valid),
    .hint       (hint),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pair table mirror and register copies
  logic [15:0] learn_rate = RST_LEARNING_RATE;
  logic [15:0] min_conf   = RST_MIN_CONFIDENCE;
  logic [15:0] init_conf  = RST_INITIAL_CONFIDENCE;
  logic [15:0] decay      = RST_DECAY_FACTOR;
  logic [15:0] prune_thr  = RST_PRUNE_THRESHOLD;
  logic [15:0] tbl_trig [ENTRIES];
  logic [15:0] tbl_fol  [ENTRIES];
  logic [15:0] tbl_conf [ENTRIES];
  int          tbl_count = 0;
  logic [15:0] prev_id = '0;
  bit          prev_valid = 1'b0;

  cmd_t        pending_items [$];
  hint_t       hint_q [$];
  logic [15:0] id_pool [$];
  int          idle_pct = 0;

  int errors = 0;
  int n_records = 0;
  int n_queries = 0;
  int n_hints = 0;
  int peak_entries = 0;
  int full_drops = 0;
  int cycle_cnt = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    errors++;
  endtask

  // Append one item to the driver's queue.
  task automatic queue_item(input cmd_t c);
    pending_items.insert(pending_items.size(), c);
  endtask

  // Update the mirror for one accepted item and queue the hints it yields.
  task automatic apply_item(input cmd_t c);
    logic [31:0] prod;
    logic [16:0] sum;
    logic [15:0] dc;
    bit          found;
    int          kept;
    hint_t       h;
    hint_t       found_q [$];
    if (c.func == FUNC_RECORD) begin
      n_records++;
      if (prev_valid) begin
        found = 1'b0;
        for (int k = 0; k < tbl_count; k++) begin
          if (!found && tbl_trig[k] == prev_id && tbl_fol[k] == c.resource_id) begin
            prod = 32'(learn_rate) * (32'd65536 - 32'(tbl_conf[k]));
            sum = 17'(tbl_conf[k]) + 17'(prod >> 16);
            tbl_conf[k] = (sum > 17'(CONF_MAX)) ? CONF_MAX : sum[15:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (tbl_count < ENTRIES) begin
            tbl_trig[tbl_count] = prev_id;
            tbl_fol[tbl_count]  = c.resource_id;
            tbl_conf[tbl_count] = init_conf;
            tbl_count++;
            if (tbl_count > peak_entries) peak_entries = tbl_count;
          end else begin
            full_drops++;
          end
        end
      end
      // decay everything, close up the survivors in order
      kept = 0;
      for (int k = 0; k < tbl_count; k++) begin
        prod = 32'(tbl_conf[k]) * 32'(decay);
        dc = prod[31:16];
        if (dc >= prune_thr) begin
          tbl_trig[kept] = tbl_trig[k];
          tbl_fol[kept]  = tbl_fol[k];
          tbl_conf[kept] = dc;
          kept++;
        end
      end
      tbl_count  = kept;
      prev_id    = c.resource_id;
      prev_valid = 1'b1;
    end else begin
      n_queries++;
      if (prev_valid) begin
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_trig[k] == prev_id && tbl_conf[k] >= min_conf) begin
            h.followup_id = tbl_fol[k];
            h.confidence  = tbl_conf[k];
            h.last        = 1'b0;
            found_q.insert(found_q.size(), h);
          end
        end
        if (found_q.size() > 0) found_q[found_q.size()-1].last = 1'b1;
        foreach (found_q[k]) hint_q.insert(hint_q.size(), found_q[k]);
      end
    end
  endtask

  // Driver: hold an item until accepted, then pick the next one or idle.
  always @(posedge clk) begin : drv
    if (!rst) begin
      if (start && !busy) apply_item(item);
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          item  <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every hint strobe must match the oldest prediction.
  always @(posedge clk) begin : mon
    hint_t want;
    if (!rst && hint_valid) begin
      n_hints++;
      if (hint_q.size() == 0) begin
        report_mismatch("unexpected hint, followup_id", 32'(hint.followup_id), 32'hFFFF_FFFF);
      end else begin
        want = hint_q.pop_front();
        if (hint.followup_id !== want.followup_id)
          report_mismatch("followup_id", 32'(hint.followup_id), 32'(want.followup_id));
        if (hint.confidence !== want.confidence)
          report_mismatch("confidence", 32'(hint.confidence), 32'(want.confidence));
        if (hint.last !== want.last)
          report_mismatch("last", 32'(hint.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hints outstanding", cycle_cnt, hint_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_LEARNING_RATE:      learn_rate = val;
      REG_MIN_CONFIDENCE:     min_conf   = val;
      REG_INITIAL_CONFIDENCE: init_conf  = val;
      REG_DECAY_FACTOR:       decay      = val;
      REG_PRUNE_THRESHOLD:    prune_thr  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until no item is pending or in flight and every hint has arrived.
  task automatic wait_quiet();
    @(negedge clk);
    while (pending_items.size() != 0 || start || busy || hint_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic cmd_t make_item();
    cmd_t c;
    int   r;
    r = $urandom_range(99);
    c.func = (r < 30) ? FUNC_QUERY : FUNC_RECORD;
    if (r < 30 || r >= 90) c.resource_id = 16'($urandom);  // query id is don't-care
    else c.resource_id = id_pool[$urandom_range(id_pool.size() - 1)];
    return c;
  endfunction

  task automatic run_phase(input logic [15:0] lr, input logic [15:0] mc,
                           input logic [15:0] ic, input logic [15:0] df,
                           input logic [15:0] pt, input int idle, input int n_items,
                           input int pool_n);
    wait_quiet();
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_MIN_CONFIDENCE, mc);
    write_reg(REG_INITIAL_CONFIDENCE, ic);
    write_reg(REG_DECAY_FACTOR, df);
    write_reg(REG_PRUNE_THRESHOLD, pt);
    // an index past the last register must change nothing
    write_reg(CFG_INDEX_W'(REG_PRUNE_THRESHOLD + 1 + $urandom_range(2)), 16'($urandom));
    id_pool.delete();
    id_pool.insert(id_pool.size(), 16'h0000);
    id_pool.insert(id_pool.size(), 16'hFFFF);
    for (int k = 2; k < pool_n; k++) id_pool.insert(id_pool.size(), 16'($urandom));
    @(negedge clk);
    idle_pct = idle;
    for (int k = 0; k < n_items; k++) queue_item(make_item());
  endtask

  function automatic cmd_t mk(input logic f, input logic [15:0] id);
    cmd_t c;
    c.func        = f;
    c.resource_id = id;
    return c;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers
    @(negedge clk);
    queue_item(mk(FUNC_QUERY, 16'h1234));    // nothing recorded yet
    queue_item(mk(FUNC_RECORD, 16'h0000));   // first record, no pair
    queue_item(mk(FUNC_QUERY, 16'hFFFF));    // empty table
    for (int k = 0; k < 6; k++) begin
      queue_item(mk(FUNC_RECORD, 16'hFFFF));
      queue_item(mk(FUNC_RECORD, 16'h0000));
    end
    queue_item(mk(FUNC_QUERY, 16'h0000));
    queue_item(mk(FUNC_RECORD, 16'h5A5A));
    queue_item(mk(FUNC_RECORD, 16'hA5A5));
    queue_item(mk(FUNC_QUERY, 16'h0F0F));
    queue_item(mk(FUNC_RECORD, 16'hFFFF));
    queue_item(mk(FUNC_QUERY, 16'hF0F0));

    // Random: no pruning and slow decay first, so the table fills and drops pairs
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 90, 12);
    run_phase(16'd6554, 16'd20000, 16'd30000, 16'd64881, 16'd6554, 81, 80, 6);
    run_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 40, 5);
    run_phase(16'd40000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14, 40, 5);
    run_phase(16'($urandom), 16'($urandom_range(40000)), 16'($urandom),
              16'($urandom_range(65535, 60000)), 16'($urandom_range(8000)), 81, 80, 8);
    run_phase(16'd32768, 16'd16384, 16'd50000, 16'd65000, 16'd1000, 14, 80, 6);

    wait_quiet();
    $display("covered %0d records and %0d queries, %0d hints checked", n_records,
             n_queries, n_hints);
    $display("table peaked at %0d entries, %0d pairs dropped on a full table",
             peak_entries, full_drops);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
